// ===== rtl/subtractive_random_generator_defines.svh =====
// ---------------------------------------------------------------------------
// subtractive_random_generator_defines.svh
// Assertion macros shared by the generator RTL.
// ---------------------------------------------------------------------------
`ifndef SUBTRACTIVE_RANDOM_GENERATOR_DEFINES_SVH
`define SUBTRACTIVE_RANDOM_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SRG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define SRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/srg_pkg.sv =====
// ---------------------------------------------------------------------------
// srg_pkg
// Types, constants and sequencer states of the subtractive generator.
// ---------------------------------------------------------------------------
package srg_pkg;

   localparam int DATA_W        = 30;
   localparam int TABLE_LEN     = 55;
   localparam int ADDR_W        = $clog2(TABLE_LEN);
   localparam int SCATTER_STEP  = 21;
   localparam int AHEAD_OFFSET  = 30;
   localparam int TRAIL_START   = 31;
   localparam int WARMUP_ROUNDS = 4;
   localparam int ROUND_W       = $clog2(WARMUP_ROUNDS + 1);

   typedef logic [DATA_W-1:0]  data_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [ROUND_W-1:0] round_type;

   localparam data_type MODULUS = 30'd1000000000;

   typedef enum logic [0:0] {
      OP_NEXT   = 1'b0,
      OP_RESEED = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCATTER,
      ST_WARM_RD_SELF,
      ST_WARM_RD_OTHER,
      ST_WARM_WRITE,
      ST_NEXT_RD_TRAIL,
      ST_NEXT_WRITE,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/srg_ram.sv =====
// ---------------------------------------------------------------------------
// srg_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module srg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/srg_modsub.sv =====
// ---------------------------------------------------------------------------
// srg_modsub
// Shared modular subtractor: (a - b) mod 1e9 for operands below 1e9.
// ---------------------------------------------------------------------------
module srg_modsub import srg_pkg::*; (
   input  data_type op_a,
   input  data_type op_b,
   output data_type result
);

   logic [DATA_W:0] diff;

   // subtract, then add the modulus back on borrow
   assign diff   = {1'b0, op_a} - {1'b0, op_b};
   assign result = diff[DATA_W] ? (diff[DATA_W-1:0] + MODULUS) : diff[DATA_W-1:0];

endmodule

// ===== rtl/subtractive_random_generator.sv =====
// ---------------------------------------------------------------------------
// subtractive_random_generator
// Lag-55 subtractive random generator over a 55-word table modulo 1e9.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall): one word carries req_opcode and
//   req_seed_value. Opcode next returns the next integer in 0..999999999;
//   opcode reseed rebuilds the table from the seed (reduced below 1e9) and
//   echoes the seed it used, with rsp_was_reseed set.
//   Response channel (rsp_valid / rsp_stall): one word per request, in order.
//   Sequence: a next request reads two entries, writes the update, then
//   loads the output; a reseed writes the reduced seed, makes 54 scatter
//   writes, then 4 x 55 warm-up updates, then the output load.
//   Every table update goes through one modular subtractor and one RAM
//   read port, so each update needs two reads in sequence before its write.
//   req_stall is high while a request is in progress. A finished word waits
//   in the output register while rsp_stall is high; the block then holds its
//   next result until that register frees up.
//   Reset clears both pointers, the output valid flag and the per-entry valid
//   bits, so the table reads as all zero until written.
// ---------------------------------------------------------------------------
`include "subtractive_random_generator_defines.svh"

module subtractive_random_generator import srg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [0:0]  req_opcode,
   input  data_type    req_seed_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output data_type    rsp_value,
   output logic        rsp_was_reseed
);

   state_type state_ff, state_in;
   addr_type  lead_ff, lead_in;
   addr_type  trail_ff, trail_in;
   addr_type  pos_ff, pos_in;
   addr_type  step_ff, step_in;
   round_type round_ff, round_in;
   data_type  seed_ff, seed_in;
   data_type  prev_ff, prev_in;
   data_type  cur_ff, cur_in;
   data_type  opnd_ff, opnd_in;
   data_type  res_ff, res_in;
   logic      res_reseed_ff, res_reseed_in;
   logic      rsp_valid_ff, rsp_valid_in;
   data_type  rsp_value_ff, rsp_value_in;
   logic      rsp_reseed_ff, rsp_reseed_in;
   logic [TABLE_LEN-1:0] valid_ff, valid_in;
   logic      rd_valid_ff;

   logic      wr_en;
   addr_type  wr_addr;
   data_type  wr_data;
   addr_type  rd_addr;
   data_type  rd_data;
   data_type  rd_val;
   data_type  unit_a, unit_b, unit_res;
   addr_type  lead_adv, trail_adv;
   addr_type  other_addr;
   logic [ADDR_W:0] pos_sum;
   addr_type  pos_next;

   srg_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TABLE_LEN)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   srg_modsub u_modsub (
      .op_a   (unit_a),
      .op_b   (unit_b),
      .result (unit_res)
   );

   // never-written entries read as zero
   assign rd_val = rd_valid_ff ? rd_data : '0;

   // advance pointers, wrapping past the last position to the first
   assign lead_adv  = (lead_ff == ADDR_W'(TABLE_LEN)) ? ADDR_W'(1) : lead_ff + ADDR_W'(1);
   assign trail_adv = (trail_ff == ADDR_W'(TABLE_LEN)) ? ADDR_W'(1) : trail_ff + ADDR_W'(1);

   // entry thirty-one places ahead of the current entry, as a RAM address
   assign other_addr = (step_ff >= ADDR_W'(TABLE_LEN - AHEAD_OFFSET))
                     ? step_ff - ADDR_W'(TABLE_LEN - AHEAD_OFFSET)
                     : step_ff + ADDR_W'(AHEAD_OFFSET);

   // next scatter position, stepping by 21 modulo 55
   assign pos_sum  = {1'b0, pos_ff} + (ADDR_W + 1)'(SCATTER_STEP);
   assign pos_next = (pos_sum >= (ADDR_W + 1)'(TABLE_LEN))
                   ? ADDR_W'(pos_sum - (ADDR_W + 1)'(TABLE_LEN))
                   : pos_sum[ADDR_W-1:0];

   // sequencer: next state, datapath steering and register updates
   always_comb begin
      state_in      = state_ff;
      lead_in       = lead_ff;
      trail_in      = trail_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      round_in      = round_ff;
      seed_in       = seed_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      opnd_in       = opnd_ff;
      res_in        = res_ff;
      res_reseed_in = res_reseed_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_reseed_in = rsp_reseed_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = unit_res;
      rd_addr       = '0;
      unit_a        = opnd_ff;
      unit_b        = rd_val;

      case (state_ff)
         ST_IDLE: begin
            // look up the entry after the lead pointer ahead of time
            rd_addr = (lead_ff == ADDR_W'(TABLE_LEN)) ? '0 : lead_ff;
            unit_a  = req_seed_value;
            unit_b  = MODULUS;
            if (req_valid) begin
               if (req_opcode == OP_RESEED) begin
                  wr_en    = 1'b1;
                  wr_addr  = ADDR_W'(TABLE_LEN - 1);
                  wr_data  = unit_res;
                  seed_in  = unit_res;
                  prev_in  = unit_res;
                  cur_in   = DATA_W'(1);
                  pos_in   = ADDR_W'(SCATTER_STEP);
                  step_in  = ADDR_W'(1);
                  state_in = ST_SCATTER;
               end else begin
                  lead_in  = lead_adv;
                  trail_in = trail_adv;
                  state_in = ST_NEXT_RD_TRAIL;
               end
            end
         end
         ST_SCATTER: begin
            // store the running difference at the scattered position
            wr_en   = 1'b1;
            wr_addr = pos_ff - ADDR_W'(1);
            wr_data = cur_ff;
            unit_a  = prev_ff;
            unit_b  = cur_ff;
            cur_in  = unit_res;
            prev_in = cur_ff;
            pos_in  = pos_next;
            if (step_ff == ADDR_W'(TABLE_LEN - 1)) begin
               step_in  = ADDR_W'(1);
               round_in = '0;
               state_in = ST_WARM_RD_SELF;
            end else begin
               step_in = step_ff + ADDR_W'(1);
            end
         end
         ST_WARM_RD_SELF: begin
            rd_addr  = step_ff - ADDR_W'(1);
            state_in = ST_WARM_RD_OTHER;
         end
         ST_WARM_RD_OTHER: begin
            opnd_in  = rd_val;
            rd_addr  = other_addr;
            state_in = ST_WARM_WRITE;
         end
         ST_WARM_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = step_ff - ADDR_W'(1);
            if (step_ff == ADDR_W'(TABLE_LEN)) begin
               step_in = ADDR_W'(1);
               if (round_ff == ROUND_W'(WARMUP_ROUNDS - 1)) begin
                  res_in        = seed_ff;
                  res_reseed_in = 1'b1;
                  lead_in       = '0;
                  trail_in      = ADDR_W'(TRAIL_START);
                  state_in      = ST_FINISH;
               end else begin
                  round_in = round_ff + ROUND_W'(1);
                  state_in = ST_WARM_RD_SELF;
               end
            end else begin
               step_in  = step_ff + ADDR_W'(1);
               state_in = ST_WARM_RD_SELF;
            end
         end
         ST_NEXT_RD_TRAIL: begin
            opnd_in  = rd_val;
            rd_addr  = trail_ff - ADDR_W'(1);
            state_in = ST_NEXT_WRITE;
         end
         ST_NEXT_WRITE: begin
            wr_en         = 1'b1;
            wr_addr       = lead_ff - ADDR_W'(1);
            res_in        = unit_res;
            res_reseed_in = 1'b0;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_ff;
               rsp_reseed_in = res_reseed_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // mark written entries valid
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff      <= '0;
         trail_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         lead_ff      <= lead_in;
         trail_ff     <= trail_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= valid_ff[rd_addr];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      round_ff      <= round_in;
      seed_ff       <= seed_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      opnd_ff       <= opnd_in;
      res_ff        <= res_in;
      res_reseed_ff <= res_reseed_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_reseed_ff <= rsp_reseed_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_was_reseed = rsp_reseed_ff;

   // an accepted request blocks the input on the following cycle
   `SRG_ASSERT_NEXT(a_accept_blocks, clock, reset, req_valid && !req_stall, req_stall,
      "request channel open right after an accept")

   // table writes always hold a residue
   `SRG_ASSERT_NOW(a_write_residue, clock, reset, wr_en, wr_data < MODULUS,
      "table write at or above the modulus")

   // both pointers sit on real positions when a next update writes
   `SRG_ASSERT_NOW(a_ptr_range, clock, reset, state_ff == ST_NEXT_WRITE,
      lead_ff != '0 && lead_ff <= ADDR_W'(TABLE_LEN) &&
      trail_ff != '0 && trail_ff <= ADDR_W'(TABLE_LEN),
      "pointer outside the table during a next update")

   // a free output register takes the finished word and reopens the input
   `SRG_ASSERT_NEXT(a_finish_loads, clock, reset,
      state_ff == ST_FINISH && (!rsp_valid_ff || !rsp_stall),
      rsp_valid_ff && state_ff == ST_IDLE,
      "finished word not loaded into the output register")

endmodule
